FILE: rtl/pmed_pkg.sv
// Package for the PIR motion event detector: event codes, register indexes,
// field widths and the structs passed between the detector modules.
// No dependencies; every other file in rtl imports this package.
package pmed_pkg;

  // Fixed field widths.
  localparam int unsigned CodeWidth   = 2;
  localparam int unsigned PortTimeW   = 32;
  localparam int unsigned RegTimeW    = 24;
  localparam int unsigned SensorWidth = 8;
  localparam int unsigned CfgIdxWidth = 8;
  localparam int unsigned CfgDataW    = 24;

  // Event codes reported on the result channel.
  typedef enum logic [CodeWidth-1:0] {
    EV_CALIBRATING = 2'd0,
    EV_ACTIVE      = 2'd1,
    EV_DETECTED    = 2'd2,
    EV_ENDED       = 2'd3
  } event_code_t;

  // Configuration register indexes.
  localparam logic [CfgIdxWidth-1:0] REG_CALIB_TIME = 8'd0;
  localparam logic [CfgIdxWidth-1:0] REG_PAUSE_TIME = 8'd1;
  localparam logic [CfgIdxWidth-1:0] REG_SENSOR_ID  = 8'd2;

  // Reset values of the configuration registers.
  localparam logic [RegTimeW-1:0]    CALIB_RESET  = 24'd30000;
  localparam logic [RegTimeW-1:0]    PAUSE_RESET  = 24'd5000;
  localparam logic [SensorWidth-1:0] SENSOR_RESET = 8'd0;

  // Current configuration as seen by the event logic.
  typedef struct packed {
    logic [RegTimeW-1:0]    calib_time;
    logic [RegTimeW-1:0]    pause_time;
    logic [SensorWidth-1:0] sensor_id;
  } cfg_t;

  // One result item before it enters the output register.
  typedef struct packed {
    logic                   emit;
    event_code_t            code;
    logic [PortTimeW-1:0]   event_time;
    logic [SensorWidth-1:0] sensor;
  } result_t;

endpackage

FILE: rtl/pmed_cfg_regs.sv
// Configuration register file of the PIR motion event detector.
// Depends on pmed_pkg for register indexes, reset values and cfg_t.
module pmed_cfg_regs (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             wr_en,
  input  logic [pmed_pkg::CfgIdxWidth-1:0] wr_index,
  input  logic [pmed_pkg::CfgDataW-1:0]    wr_data,
  output pmed_pkg::cfg_t                   cfg
);
  import pmed_pkg::*;

  cfg_t regs;

  // Register writes; an index beyond the list is ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      regs.calib_time <= CALIB_RESET;
      regs.pause_time <= PAUSE_RESET;
      regs.sensor_id  <= SENSOR_RESET;
    end else if (wr_en) begin
      case (wr_index)
        REG_CALIB_TIME: regs.calib_time <= wr_data;
        REG_PAUSE_TIME: regs.pause_time <= wr_data;
        REG_SENSOR_ID:  regs.sensor_id  <= wr_data[SensorWidth-1:0];
        default: ;
      endcase
    end
  end

  assign cfg = regs;

endmodule

FILE: rtl/pmed_event_logic.sv
// Detector state and the single-pass event decision for one poll.
// Depends on pmed_pkg for event codes, cfg_t and result_t.
module pmed_event_logic #(
  parameter int unsigned TIME_WIDTH = 32
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           advance,
  input  logic                           motion_level,
  input  logic [pmed_pkg::PortTimeW-1:0] now_ms,
  input  pmed_pkg::cfg_t                 cfg,
  output pmed_pkg::result_t              result
);
  import pmed_pkg::*;

  localparam int unsigned TW = TIME_WIDTH;
  localparam int unsigned CW = TW + RegTimeW;

  // Detector state.
  logic          started, started_next;
  logic          calibrated, calibrated_next;
  logic          lock_low, lock_low_next;
  logic          take_low, take_low_next;
  logic [TW-1:0] calib_start, calib_start_next;
  logic [TW-1:0] low_since, low_since_next;
  logic [TW-1:0] motion_start, motion_start_next;

  // Times in the internal width; the port time is extended or cut to TW bits.
  logic [TW+PortTimeW-1:0] now_ext;
  logic [TW-1:0]           now_t;
  logic [CW-1:0]           pause_ext;
  logic [TW-1:0]           pause_t;
  logic [TW-1:0]           calib_diff;
  logic [TW-1:0]           low_diff;
  logic [TW-1:0]           duration;
  logic [TW+PortTimeW-1:0] out_ext;
  logic                    calib_pass;
  logic                    pause_pass;

  assign now_ext   = {{TW{1'b0}}, now_ms};
  assign now_t     = now_ext[TW-1:0];
  assign pause_ext = {{TW{1'b0}}, cfg.pause_time};
  assign pause_t   = pause_ext[TW-1:0];

  // Decision for the current poll and the state it leaves behind.
  always_comb begin
    started_next      = 1'b1;
    calibrated_next   = calibrated;
    lock_low_next     = lock_low;
    take_low_next     = take_low;
    low_since_next    = low_since;
    motion_start_next = motion_start;
    calib_start_next  = started ? calib_start : now_t;
    calib_diff        = now_t - calib_start_next;
    calib_pass        = {{RegTimeW{1'b0}}, calib_diff} > {{TW{1'b0}}, cfg.calib_time};
    low_diff          = '0;
    pause_pass        = 1'b0;
    duration          = now_t - pause_t - motion_start;
    result.emit       = 1'b0;
    result.code       = EV_CALIBRATING;
    out_ext           = {{PortTimeW{1'b0}}, now_t};

    if (!calibrated) begin
      result.emit = 1'b1;
      if (calib_pass) begin
        calibrated_next = 1'b1;
        result.code     = EV_ACTIVE;
      end
    end else if (motion_level) begin
      take_low_next = 1'b1;
      if (lock_low) begin
        lock_low_next     = 1'b0;
        motion_start_next = now_t;
        result.emit       = 1'b1;
        result.code       = EV_DETECTED;
      end
    end else begin
      // The first low poll of a sequence starts the pause interval.
      if (take_low) begin
        low_since_next = now_t;
        take_low_next  = 1'b0;
      end
      low_diff   = now_t - low_since_next;
      pause_pass = {{RegTimeW{1'b0}}, low_diff} > {{TW{1'b0}}, cfg.pause_time};
      if (!lock_low && pause_pass) begin
        lock_low_next = 1'b1;
        result.emit   = 1'b1;
        result.code   = EV_ENDED;
        out_ext       = {{PortTimeW{1'b0}}, duration};
      end
    end

    result.event_time = out_ext[PortTimeW-1:0];
    result.sensor     = cfg.sensor_id;
  end

  // Control flags advance with each poll that leaves the input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      started    <= 1'b0;
      calibrated <= 1'b0;
      lock_low   <= 1'b1;
      take_low   <= 1'b0;
    end else if (advance) begin
      started    <= started_next;
      calibrated <= calibrated_next;
      lock_low   <= lock_low_next;
      take_low   <= take_low_next;
    end
  end

  // Time stamps of the current calibration, pause and motion sequence.
  always_ff @(posedge clk) begin
    if (rst) begin
      calib_start  <= '0;
      low_since    <= '0;
      motion_start <= '0;
    end else if (advance) begin
      calib_start  <= calib_start_next;
      low_since    <= low_since_next;
      motion_start <= motion_start_next;
    end
  end

endmodule

FILE: rtl/pir_motion_event_detector_core.sv
// PIR motion event detector: a poll is registered, decided in one pass and the
// result is held in an output register. A poll accepted into the input register is
// decided and its result captured into the output register once that register is
// free; one poll is taken every cycle while results drain. Synchronous active-high
// reset clears the valid flags and detector state and loads register defaults.
// Depends on pmed_pkg, pmed_cfg_regs and pmed_event_logic.
module pir_motion_event_detector_core #(
  parameter int unsigned TIME_WIDTH = 32
) (
  input  logic                             clk,
  input  logic                             rst,
  // Poll input.
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [39:0]                      s_tdata,  // motion_level[0], now_ms[32:1], zero pad
  // Event output.
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [39:0]                      m_tdata,  // event_time[31:0], event_sensor[39:32]
  output logic [pmed_pkg::CodeWidth-1:0]   m_tuser,  // event_code[1:0]
  // Configuration write channel.
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [pmed_pkg::CfgIdxWidth-1:0] cfg_index,
  input  logic [pmed_pkg::CfgDataW-1:0]    cfg_data
);
  import pmed_pkg::*;

  cfg_t    cfg;
  result_t result;

  // Input register.
  logic                 in_valid;
  logic                 in_level;
  logic [PortTimeW-1:0] in_time;
  logic                 advance;

  // Output register.
  logic                   out_valid;
  event_code_t            out_code;
  logic [PortTimeW-1:0]   out_time;
  logic [SensorWidth-1:0] out_sensor;

  assign cfg_ready = 1'b1;

  pmed_cfg_regs u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid & cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  // The registered poll moves on once the output register is free.
  assign advance  = in_valid & (~out_valid | m_tready);
  assign s_tready = ~in_valid | advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready & s_tvalid) begin
      in_level <= s_tdata[0];
      in_time  <= s_tdata[PortTimeW:1];
    end
  end

  pmed_event_logic #(
    .TIME_WIDTH (TIME_WIDTH)
  ) u_logic (
    .clk          (clk),
    .rst          (rst),
    .advance      (advance),
    .motion_level (in_level),
    .now_ms       (in_time),
    .cfg          (cfg),
    .result       (result)
  );

  // Result register; a poll without an event leaves it empty.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= result.emit;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance & result.emit) begin
      out_code   <= result.code;
      out_time   <= result.event_time;
      out_sensor <= result.sensor;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {out_sensor, out_time};
  assign m_tuser  = out_code;

endmodule

FILE: rtl/pmed_checker.sv
// Port-level checks for the PIR motion event detector, bound to the top level.
// Depends on pmed_pkg for the code width.
module pmed_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           s_tready,
  input logic                           m_tvalid,
  input logic                           m_tready,
  input logic [39:0]                    m_tdata,
  input logic [pmed_pkg::CodeWidth-1:0] m_tuser
);
  import pmed_pkg::*;

  // A stalled result stays offered.
  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("result withdrawn while stalled");

  // A stalled result keeps its payload.
  a_hold_data: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
    else $error("result payload changed while stalled");

  // With the output register empty the block always takes a poll.
  a_no_stall_empty: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input stalled with empty output register");

  // Reset empties the output register.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result valid right after reset");

endmodule

bind pir_motion_event_detector_core pmed_checker u_pmed_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

FILE: test/tb_top.sv
// Self-checking testbench for pir_motion_event_detector_core: streams sensor polls,
// predicts the emitted events and checks every event transaction field by field.
// Depends on pmed_pkg and the detector RTL.
module tb_top;
  import pmed_pkg::*;

  localparam int unsigned CycleLimit = 400000;

  // One predicted event.
  typedef struct {
    event_code_t     code;
    logic [31:0]     stamp;
    logic [7:0]      sensor;
  } pir_event_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [39:0]            s_tdata = '0;     // motion_level[0], now_ms[32:1], zero pad
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [39:0]            m_tdata;          // event_time[31:0], event_sensor[39:32]
  logic [CodeWidth-1:0]   m_tuser;          // event_code[1:0]
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CfgIdxWidth-1:0] cfg_index = '0;
  logic [CfgDataW-1:0]    cfg_data = '0;

  pir_motion_event_detector_core DUT (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Polls waiting to be sent, packed as {now_ms, motion_level}.
  logic [32:0] poll_q[$];
  pir_event_t  predicted_events[$];

  // Shadow configuration and detector state.
  logic [23:0] cfg_calib  = CALIB_RESET;
  logic [23:0] cfg_pause  = PAUSE_RESET;
  logic [7:0]  cfg_sensor = SENSOR_RESET;
  logic        started    = 1'b0;
  logic        calibrated = 1'b0;
  logic        armed      = 1'b1;
  logic        low_pending = 1'b0;
  logic [31:0] cal_start  = '0;
  logic [31:0] low_from   = '0;
  logic [31:0] motion_t0  = '0;

  int unsigned err_cnt    = 0;
  int unsigned polls_in   = 0;
  int unsigned cfg_writes = 0;
  int unsigned cycle_cnt  = 0;
  int unsigned code_seen[4] = '{0, 0, 0, 0};

  // Work out the event, if any, that one poll causes.
  function automatic void predict_event(input logic level, input logic [31:0] now);
    pir_event_t ev;
    logic       fire;
    fire      = 1'b0;
    ev.code   = EV_CALIBRATING;
    ev.stamp  = now;
    ev.sensor = cfg_sensor;
    if (!started) begin
      started   = 1'b1;
      cal_start = now;
    end
    if (!calibrated) begin
      fire = 1'b1;
      if ((now - cal_start) > {8'd0, cfg_calib}) begin
        calibrated = 1'b1;
        ev.code    = EV_ACTIVE;
      end
    end else if (level) begin
      low_pending = 1'b1;
      if (armed) begin
        armed     = 1'b0;
        motion_t0 = now;
        fire      = 1'b1;
        ev.code   = EV_DETECTED;
      end
    end else begin
      if (low_pending) begin
        low_from    = now;
        low_pending = 1'b0;
      end
      // Motion ends only once the low level lasts strictly longer than the pause.
      if (!armed && (now - low_from) > {8'd0, cfg_pause}) begin
        armed    = 1'b1;
        fire     = 1'b1;
        ev.code  = EV_ENDED;
        ev.stamp = now - {8'd0, cfg_pause} - motion_t0;
      end
    end
    if (fire) predicted_events.push_back(ev);
  endfunction

  function automatic void queue_poll(input logic level, input logic [31:0] now);
    poll_q.push_back({now, level});
  endfunction

  // Driver: bursts of random length separated by random gaps.
  int unsigned burst_left = 1;
  int unsigned gap_left   = 0;
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid   <= 1'b0;
      s_tdata    <= '0;
      burst_left = 1;
      gap_left   = 0;
    end else begin
      if (s_tvalid && s_tready) begin
        predict_event(s_tdata[0], s_tdata[32:1]);
        polls_in++;
      end
      if (!(s_tvalid && !s_tready)) begin
        if (gap_left > 0) begin
          gap_left--;
          s_tvalid <= 1'b0;
        end else if (poll_q.size() > 0) begin
          s_tdata  <= {7'd0, poll_q.pop_front()};
          s_tvalid <= 1'b1;
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 24);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
          end else begin
            burst_left--;
          end
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver: a stall pattern re-chosen at random from four modes, plus two long hold-offs.
  int unsigned rx_cnt     = 0;
  int unsigned rx_mode    = 0;
  int unsigned hold_left  = 0;
  int unsigned holds_done = 0;
  always @(posedge clk) begin
    if (rst) begin
      m_tready   <= 1'b0;
      rx_cnt     = 0;
      hold_left  = 0;
      holds_done = 0;
    end else begin
      rx_cnt++;
      if (rx_cnt % 128 == 0) rx_mode = $urandom_range(0, 3);
      if (hold_left == 0 && ((holds_done == 0 && polls_in >= 500) ||
                             (holds_done == 1 && polls_in >= 1400))) begin
        hold_left = 160;
        holds_done++;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        case (rx_mode)
          0: m_tready <= 1'b1;
          1: m_tready <= 1'($urandom_range(0, 1));
          2: m_tready <= ($urandom_range(0, 3) == 0);
          default: m_tready <= (rx_cnt % 8 != 0);
        endcase
      end
    end
  end

  // Monitor: compare each event transaction with the oldest prediction.
  always @(posedge clk) begin
    pir_event_t ev;
    if (!rst && m_tvalid && m_tready) begin
      if (predicted_events.size() == 0) begin
        $error("unexpected event: code %0d time %0d sensor %0d",
               m_tuser, m_tdata[31:0], m_tdata[39:32]);
        err_cnt++;
      end else begin
        ev = predicted_events.pop_front();
        code_seen[ev.code]++;
        if (m_tuser !== ev.code) begin
          $error("event_code: expected %0d, actual %0d", ev.code, m_tuser);
          err_cnt++;
        end
        if (m_tdata[31:0] !== ev.stamp) begin
          $error("event_time: expected %0d, actual %0d", ev.stamp, m_tdata[31:0]);
          err_cnt++;
        end
        if (m_tdata[39:32] !== ev.sensor) begin
          $error("event_sensor: expected %0d, actual %0d", ev.sensor, m_tdata[39:32]);
          err_cnt++;
        end
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CycleLimit) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Write one configuration register and mirror it into the shadow copy.
  task automatic write_reg(input logic [CfgIdxWidth-1:0] idx, input logic [CfgDataW-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    cfg_writes++;
    if (idx == REG_CALIB_TIME) cfg_calib = val;
    else if (idx == REG_PAUSE_TIME) cfg_pause = val;
    else if (idx == REG_SENSOR_ID) cfg_sensor = val[7:0];
  endtask

  // Wait until every poll is sent and every event has arrived, then let the pipe drain.
  task automatic wait_idle();
    do @(posedge clk);
    while (poll_q.size() != 0 || s_tvalid || predicted_events.size() != 0);
    repeat (8) @(posedge clk);
  endtask

  // Mostly well-formed motion sequences around the pause time, with some noise.
  task automatic gen_phase(input int unsigned n, input logic [23:0] pause);
    int unsigned p;
    int unsigned cnt;
    int unsigned nh;
    int unsigned nl;
    logic [31:0] t;
    logic [31:0] dt;
    p   = {8'd0, pause};
    cnt = 0;
    t   = $urandom;
    while (cnt < n) begin
      if ($urandom_range(0, 9) == 0) begin
        t = $urandom_range(0, 1) ? $urandom : t + $urandom_range(0, p + 1);
        queue_poll(1'($urandom_range(0, 1)), t);
        cnt++;
      end else begin
        nh = $urandom_range(1, 4);
        nl = $urandom_range(1, 5);
        repeat (nh) begin
          t = t + $urandom_range(0, p / 4 + 2);
          queue_poll(1'b1, t);
        end
        for (int j = 0; j < nl; j++) begin
          if (j == 0) begin
            dt = $urandom_range(0, p / 4 + 2);
          end else begin
            case ($urandom_range(0, 3))
              0: dt = p;
              1: dt = p + 1;
              2: dt = $urandom_range(0, p / 2 + 1);
              default: dt = $urandom_range(p, 2 * p + 2);
            endcase
          end
          t = t + dt;
          queue_poll(1'b0, t);
        end
        cnt += nh + nl;
      end
    end
  endtask

  // Stimulus sequencing.
  initial begin
    logic [31:0] t0;
    logic [31:0] tb;
    logic [23:0] pause_set[8];
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Calibration at the largest time, across the 32-bit wrap.
    write_reg(REG_CALIB_TIME, 24'hFFFFFF);
    t0 = 32'hFFFF_FFF0;
    queue_poll(1'b1, t0);                 // first poll starts calibration
    queue_poll(1'b0, t0 + 32'h00FF_FFFF); // exactly calib_time: still calibrating
    queue_poll(1'b1, t0 + 32'h0100_0000); // one past: active
    tb = t0 + 32'h0100_0000 + 100;
    queue_poll(1'b0, tb);                 // low with no motion: no event
    queue_poll(1'b1, tb + 10);            // detected
    queue_poll(1'b1, tb + 20);            // still high: no event
    queue_poll(1'b0, tb + 30);            // low starts
    queue_poll(1'b0, tb + 5030);          // exactly pause_time: no event
    queue_poll(1'b0, tb + 5031);          // ended
    queue_poll(1'b1, tb + 6000);
    queue_poll(1'b0, tb + 6001);
    queue_poll(1'b1, tb + 6002);          // high again restarts the low interval
    queue_poll(1'b0, tb + 6003);
    queue_poll(1'b0, tb + 11004);
    // Time running backwards looks like a very long low interval.
    queue_poll(1'b1, tb + 12000);
    queue_poll(1'b0, tb + 12001);
    queue_poll(1'b0, tb + 100);
    wait_idle();

    write_reg(REG_CALIB_TIME, 24'd0);
    write_reg(REG_SENSOR_ID, 24'd255);
    // Extremes of the time field.
    queue_poll(1'b1, 32'hFFFF_FFFF);
    queue_poll(1'b0, 32'h0000_0000);
    queue_poll(1'b0, 32'd5001);
    wait_idle();

    // Random phases over several pause settings.
    pause_set = '{24'd0, 24'd1, 24'd37, 24'd5000, 24'hFFFFFF, 24'd0, 24'd250, 24'd3};
    pause_set[5] = 24'($urandom_range(0, 24'hFFFFFF));
    for (int ph = 0; ph < 8; ph++) begin
      write_reg(REG_PAUSE_TIME, pause_set[ph]);
      write_reg(REG_SENSOR_ID,
                (ph == 0) ? 24'd0 : (ph == 1) ? 24'd255 : CfgDataW'($urandom));
      write_reg(REG_CALIB_TIME,
                (ph % 3 == 0) ? 24'hFFFFFF : (ph % 3 == 1) ? 24'd0 : CfgDataW'($urandom));
      // Writes beyond the register list must be ignored.
      write_reg(CfgIdxWidth'($urandom_range(3, 255)), CfgDataW'($urandom));
      gen_phase(240, pause_set[ph]);
      wait_idle();
    end

    repeat (10) @(posedge clk);
    if (predicted_events.size() != 0) begin
      $error("%0d predicted events never arrived", predicted_events.size());
      err_cnt++;
    end
    $display("Run covered %0d polls and %0d register writes over 8 pause settings.",
             polls_in, cfg_writes);
    $display("Events seen: calibrating %0d, active %0d, detected %0d, ended %0d.",
             code_seen[0], code_seen[1], code_seen[2], code_seen[3]);
    if (err_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
